// ===== rtl/jtl_pkg.sv =====
package jtl_pkg;

   // Lexer modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_STR  = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;
   localparam logic [1:0] MODE_BARE = 2'd3;

   // Token kinds
   localparam logic [1:0] KIND_PUNCT = 2'd0;
   localparam logic [1:0] KIND_STR   = 2'd1;
   localparam logic [1:0] KIND_BARE  = 2'd2;

   // Input commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOS  = 1'b1;

   // Characters the lexer looks at
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   // Control bytes that escape letters stand for
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   // Result queue holds up to two results
   localparam int unsigned QDEPTH = 2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] token_kind;
      logic       byte_valid;
      logic       token_end;
      logic       stream_done;
      logic       escape_error;
      logic       open_discarded;
      logic       last;
   } result_type;

   // Decode of one input item: how many results and what they are
   typedef struct packed {
      logic [1:0] cnt;
      result_type res0;
      result_type res1;
   } decode_type;

endpackage

// ===== rtl/jtl_decode.sv =====
module jtl_decode
   import jtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_cmd,
   input  logic [7:0] item_byte,
   input  logic       take,
   output decode_type dec
);

   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic       is_ws;
   logic       is_punct;
   logic       is_close;

   // character classes
   assign is_ws    = (item_byte == CH_SPACE) || ((item_byte >= CH_TAB) && (item_byte <= CH_CR));
   assign is_close = (item_byte == CH_COMMA) || (item_byte == CH_RBRACE) ||
                     (item_byte == CH_RBRACK);
   assign is_punct = is_close || (item_byte == CH_LBRACE) || (item_byte == CH_LBRACK) ||
                     (item_byte == CH_COLON);

   // result generation and next mode
   always_comb begin
      dec     = '0;
      mode_in = mode_ff;
      dec.res0.last = 1'b1;
      dec.res1.last = 1'b1;
      if (item_cmd == CMD_EOS) begin
         dec.cnt                 = 2'd1;
         dec.res0.stream_done    = 1'b1;
         dec.res0.escape_error   = (mode_ff == MODE_ESC);
         dec.res0.open_discarded = (mode_ff != MODE_IDLE);
         mode_in                 = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               dec.res0.out_byte   = item_byte;
               dec.res0.byte_valid = 1'b1;
               if (is_punct) begin
                  dec.cnt                = 2'd1;
                  dec.res0.token_kind    = KIND_PUNCT;
                  dec.res0.token_end     = 1'b1;
               end else if (item_byte == CH_QUOTE) begin
                  dec.cnt             = 2'd1;
                  dec.res0.token_kind = KIND_STR;
                  mode_in             = MODE_STR;
               end else if (!is_ws) begin
                  dec.cnt             = 2'd1;
                  dec.res0.token_kind = KIND_BARE;
                  mode_in             = MODE_BARE;
               end
            end
            MODE_STR: begin
               dec.res0.out_byte   = item_byte;
               dec.res0.byte_valid = 1'b1;
               dec.res0.token_kind = KIND_STR;
               if (item_byte == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else if (item_byte == CH_QUOTE) begin
                  dec.cnt            = 2'd1;
                  dec.res0.token_end = 1'b1;
                  mode_in            = MODE_IDLE;
               end else begin
                  dec.cnt = 2'd1;
               end
            end
            MODE_ESC: begin
               dec.res0.byte_valid = 1'b1;
               dec.res0.token_kind = KIND_STR;
               dec.cnt             = 2'd1;
               mode_in             = MODE_STR;
               case (item_byte)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: dec.res0.out_byte = item_byte;
                  CH_B: dec.res0.out_byte = CTL_BS;
                  CH_F: dec.res0.out_byte = CTL_FF;
                  CH_N: dec.res0.out_byte = CTL_LF;
                  CH_R: dec.res0.out_byte = CTL_CR;
                  CH_T: dec.res0.out_byte = CTL_HT;
                  default: begin
                     // unknown escape letter is dropped
                     dec.cnt             = 2'd0;
                     dec.res0.byte_valid = 1'b0;
                  end
               endcase
            end
            default: begin
               // inside a bare value
               dec.cnt             = 2'd1;
               dec.res0.token_kind = KIND_BARE;
               if (is_ws || is_close) begin
                  dec.res0.token_end = 1'b1;
                  mode_in            = MODE_IDLE;
                  if (is_close) begin
                     // close marker, then the punctuation itself
                     dec.cnt              = 2'd2;
                     dec.res0.last        = 1'b0;
                     dec.res1.out_byte    = item_byte;
                     dec.res1.token_kind  = KIND_PUNCT;
                     dec.res1.byte_valid  = 1'b1;
                     dec.res1.token_end   = 1'b1;
                  end
               end else begin
                  dec.res0.out_byte   = item_byte;
                  dec.res0.byte_valid = 1'b1;
               end
            end
         endcase
      end
   end

   // mode advances only when the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (take) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== rtl/jtl_rsp_queue.sv =====
module jtl_rsp_queue
   import jtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  result_type push0,
   input  result_type push1,
   input  logic       pop,
   output logic [1:0] count,
   output logic       out_valid,
   output result_type out_data
);

   result_type slot_ff [QDEPTH];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       rd_ptr_ff;
   logic       wr_ptr_ff;
   logic       do_pop;

   assign do_pop    = pop && (count_ff != 2'd0);
   assign count     = count_ff;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + push_n - {1'b0, do_pop};

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         wr_ptr_ff <= wr_ptr_ff ^ (push_n == 2'd1);
      end
   end

   // slot storage; two pushes only happen into an empty queue
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         slot_ff[~wr_ptr_ff] <= push1;
      end
   end

endmodule

// ===== rtl/json_token_lexer.sv =====
// An accepted byte is registered in the input stage, decoded and written into the
// result queue. Throughput: one byte per cycle while the output takes beats and each
// byte gives at most one result; a bare value closed by a comma or closing bracket
// gives two beats and waits until the two-entry result queue is empty.
// Reset: synchronous, active high; clears the lexer mode to idle and empties
// the input stage and the result queue.
module json_token_lexer
   import jtl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [6:0] rsp_tuser,   // [1:0] token_kind, [2] byte_valid, [3] token_end,
                                   // [4] stream_done, [5] escape_error, [6] open_discarded
   output logic       rsp_tlast    // last
);

   logic       in_vld_ff;
   logic       in_vld_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   decode_type dec;
   logic [1:0] q_count;
   logic       fits;
   logic       adv;
   logic [1:0] push_n;
   result_type rsp;

   // input stage
   assign req_tready = !in_vld_ff || adv;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   jtl_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .item_cmd  (in_cmd_ff),
      .item_byte (in_byte_ff),
      .take      (adv),
      .dec       (dec)
   );

   // item moves on when the queue has room for all its results
   assign fits   = (q_count == 2'd0) ||
                   ((q_count == 2'd1) && (dec.cnt != 2'd2)) ||
                   (dec.cnt == 2'd0);
   assign adv    = in_vld_ff && fits;
   assign push_n = adv ? dec.cnt : 2'd0;

   jtl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (dec.res0),
      .push1     (dec.res1),
      .pop       (rsp_tready),
      .count     (q_count),
      .out_valid (rsp_tvalid),
      .out_data  (rsp)
   );

   // result beat packing
   assign rsp_tdata = rsp.out_byte;
   assign rsp_tuser = {rsp.open_discarded, rsp.escape_error, rsp.stream_done,
                       rsp.token_end, rsp.byte_valid, rsp.token_kind};
   assign rsp_tlast = rsp.last;

   // the end-of-stream status is always the only beat of its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.stream_done |-> rsp_tlast && !rsp.byte_valid)
      else $error("stream status beat not marked last");

   // an escape error can only occur with an open string
   a_esc_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.escape_error |-> rsp.open_discarded && rsp.stream_done)
      else $error("escape error without discarded token");

   // a marker beat with no byte carries a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.byte_valid |-> rsp.out_byte == 8'd0)
      else $error("marker beat carries a byte");

   // a close marker always ends a bare value
   a_close_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.byte_valid && !rsp.stream_done |->
         rsp.token_end && (rsp.token_kind == KIND_BARE))
      else $error("close marker malformed");

   // a two-beat item is only queued into an empty queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |-> q_count == 2'd0)
      else $error("result queue overflow");

endmodule
